[src/assert_macros.svh]
// Assertion macros used by the allocator back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define AST_HOLD(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/ffsa_pkg.sv]
// Shared types, codes and helpers of the first-fit segment allocator.
`timescale 1ns / 1ps
package ffsa_pkg;

  localparam int DEVICES_DEF    = 4;
  localparam int SEGMENTS_DEF   = 4096;
  localparam int VM_ID_BITS_DEF = 8;
  localparam int NUM_DESC       = 4;
  localparam int TOT_W          = 13;
  localparam int QDEPTH         = 2;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_REL   = 2'd1;
  localparam logic [1:0] KIND_ALL   = 2'd2;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_MISALIGN = 3'd1;
  localparam logic [2:0] STAT_NO_VM    = 3'd2;
  localparam logic [2:0] STAT_NO_DEV   = 3'd3;
  localparam logic [2:0] STAT_NO_SPACE = 3'd4;
  localparam logic [2:0] STAT_MISMATCH = 3'd5;

  localparam logic [2:0] CFG_SEG_SIZE = 3'd0;
  localparam logic [2:0] CFG_DEV_CNT  = 3'd1;
  localparam logic [2:0] CFG_DESC0    = 3'd2;
  localparam logic [2:0] CFG_DESC3    = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tier;
    logic [7:0]  unit;
    logic [7:0]  vm;
    logic        vm_exists;
    logic [23:0] size_mb;
    logic [23:0] offset_mb_in;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  device_index;
    logic [23:0] offset_mb_out;
    logic [23:0] granted_mb;
    logic [15:0] alignment_mb;
  } result_t;

  typedef struct packed {
    logic [15:0]                seg;
    logic [2:0]                 dev_n;
    logic [NUM_DESC-1:0][28:0] desc;
  } cfg_t;

  typedef struct packed {
    item_t      item;
    logic       dev_hit;
    logic [1:0] dev_idx;
  } cmd_t;

  // Segment count of a descriptor, saturated at the map size.
  function automatic logic [TOT_W-1:0] dev_total(input logic [28:0] desc,
                                                  input int seg_max);
    logic [TOT_W-1:0] t;
    t = desc[28:16];
    if (int'(t) > seg_max) begin
      t = TOT_W'(seg_max);
    end
    return t;
  endfunction

endpackage

[src/ffsa_front.sv]
// Front end: configuration registers, item intake and device match.
`timescale 1ns / 1ps
module ffsa_front #(
  parameter int DEVICES = ffsa_pkg::DEVICES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [28:0]     cfg_data,
  input  logic            start,
  input  ffsa_pkg::item_t item,
  input  logic            back_ready,
  input  logic            q_full,
  output logic            busy,
  output logic            push,
  output ffsa_pkg::cmd_t  cmd,
  output ffsa_pkg::cfg_t  cfg
);

  logic [15:0] seg_size;
  logic [2:0]  dev_count;
  logic [ffsa_pkg::NUM_DESC-1:0][28:0] desc;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_size  <= 16'd1;
      dev_count <= '0;
      desc      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == ffsa_pkg::CFG_SEG_SIZE) begin
        seg_size <= cfg_data[15:0];
      end else if (cfg_index == ffsa_pkg::CFG_DEV_CNT) begin
        dev_count <= cfg_data[2:0];
      end else if (cfg_index >= ffsa_pkg::CFG_DESC0 && cfg_index <= ffsa_pkg::CFG_DESC3) begin
        desc[2'(cfg_index - ffsa_pkg::CFG_DESC0)] <= cfg_data;
      end
    end
  end

  always_comb begin
    cfg.seg   = seg_size;
    cfg.dev_n = (int'(dev_count) > DEVICES) ? 3'(DEVICES) : dev_count;
    cfg.desc  = desc;
  end

  // Pick the lowest device in use whose tier and unit both match.
  always_comb begin
    cmd.item    = item;
    cmd.dev_hit = 1'b0;
    cmd.dev_idx = '0;
    for (int d = ffsa_pkg::NUM_DESC - 1; d >= 0; d--) begin
      if (d < int'(cfg.dev_n) && desc[d][7:0] == item.tier && desc[d][15:8] == item.unit) begin
        cmd.dev_hit = 1'b1;
        cmd.dev_idx = 2'(d);
      end
    end
  end

  assign busy = !back_ready || q_full;
  assign push = start && !busy;

endmodule

[src/ffsa_queue.sv]
// Short item queue between the front end and the back end.
`timescale 1ns / 1ps
module ffsa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ffsa_pkg::cmd_t push_cmd,
  input  logic           pop,
  output ffsa_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);

  ffsa_pkg::cmd_t slots [ffsa_pkg::QDEPTH];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push && !full) begin
        wp <= !wp;
      end
      if (pop && !empty) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(push && !full) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wp] <= push_cmd;
    end
  end

  assign head  = slots[rp];
  assign empty = (cnt == 2'd0);
  assign full  = (cnt == 2'(ffsa_pkg::QDEPTH));

endmodule

[src/ffsa_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ffsa_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [23:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [23:0] quot,
  output logic [15:0] rem
);

  logic [4:0]  cnt;
  logic        run;
  logic [16:0] trial;

  assign trial = {rem, quot[23]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        cnt  <= '0;
        quot <= dividend;
        rem  <= '0;
      end else if (run) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= 16'(trial - {1'b0, divisor});
          quot <= {quot[22:0], 1'b1};
        end else begin
          rem <= trial[15:0];
          quot <= {quot[22:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/ffsa_back.sv]
// Back end: segment maps, first-fit scan, release walks and results.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffsa_back #(
  parameter int DEVICES    = ffsa_pkg::DEVICES_DEF,
  parameter int SEGMENTS   = ffsa_pkg::SEGMENTS_DEF,
  parameter int VM_ID_BITS = ffsa_pkg::VM_ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ffsa_pkg::cfg_t    cfg,
  input  ffsa_pkg::cmd_t    head,
  input  logic              q_empty,
  output logic              pop,
  output logic              ready,
  output logic              done,
  output ffsa_pkg::result_t result
);

  localparam int DEPTH  = DEVICES * SEGMENTS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DEV_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int DEVC_W = $clog2(DEVICES + 1);
  localparam int TW     = ffsa_pkg::TOT_W;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV_SIZE, ST_DIV_OFFS, ST_CHECK, ST_SCAN, ST_CLAIM,
    ST_MULT, ST_REL_RD, ST_REL_CHK, ST_ALL_RD, ST_ALL_CHK, ST_RESP
  } state_t;

  state_t state;

  logic                  taken_mem [DEPTH];
  logic [VM_ID_BITS-1:0] owner_mem [DEPTH];
  logic                  taken_q;
  logic [VM_ID_BITS-1:0] owner_q;

  ffsa_pkg::cmd_t cmd;
  logic [ADDR_W-1:0] clr;
  logic [TW-1:0]     pos;
  logic [TW-1:0]     run;
  logic [TW-1:0]     need;
  logic [TW-1:0]     start_seg;
  logic [TW-1:0]     end_pos;
  logic              rv;
  logic [23:0]       quot_s;
  logic [15:0]       rem_s;
  logic [23:0]       idx;
  logic [23:0]       cnt;
  logic [DEVC_W-1:0] dev_it;
  logic [28:0]       prod;
  logic [2:0]        stat;
  logic              alloc_ok;
  logic [TW-1:0]     used [DEVICES];

  logic        div_go;
  logic [23:0] div_a;
  logic        div_done;
  logic [23:0] div_q;
  logic [15:0] div_r;

  logic [1:0]            sel_dev;
  logic [TW-1:0]         cur_total;
  logic [TW-1:0]         rd_pos;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  wr_en;
  logic                  wr_taken;
  logic                  own_en;
  logic [VM_ID_BITS-1:0] vm_id;
  logic                  own_hit;
  logic                  issue;
  logic [TW-1:0]         cpos;
  logic [TW-1:0]         run_inc;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [1:0] d,
                                               input logic [TW-1:0] p);
    return ADDR_W'(d) * ADDR_W'(SEGMENTS) + ADDR_W'(p);
  endfunction

  ffsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (cfg.seg),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign vm_id     = VM_ID_BITS'(cmd.item.vm);
  assign own_hit   = taken_q && (owner_q == vm_id);
  assign sel_dev   = (state == ST_ALL_RD || state == ST_ALL_CHK) ? 2'(dev_it) : cmd.dev_idx;
  assign cur_total = ffsa_pkg::dev_total(cfg.desc[sel_dev], SEGMENTS);
  assign issue     = pos < cur_total;
  assign cpos      = pos - TW'(1);
  assign run_inc   = run + TW'(1);
  assign rd_pos    = (state == ST_REL_RD) ? idx[TW-1:0] : pos;
  assign rd_addr   = addr_of(sel_dev, rd_pos);
  assign pop       = (state == ST_IDLE) && !q_empty;
  assign ready     = (state != ST_CLEAR);

  always_comb begin
    wr_en    = 1'b0;
    own_en   = 1'b0;
    wr_taken = 1'b0;
    wr_addr  = rd_addr;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr;
      end
      ST_CLAIM: begin
        wr_en    = 1'b1;
        own_en   = 1'b1;
        wr_taken = 1'b1;
      end
      ST_REL_CHK: begin
        wr_en   = own_hit;
        wr_addr = addr_of(sel_dev, idx[TW-1:0]);
      end
      ST_ALL_CHK: begin
        wr_en = own_hit;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      taken_mem[wr_addr] <= wr_taken;
    end
    if (own_en) begin
      owner_mem[wr_addr] <= vm_id;
    end
    taken_q <= taken_mem[rd_addr];
    owner_q <= owner_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr      <= '0;
      done     <= 1'b0;
      div_go   <= 1'b0;
      rv       <= 1'b0;
      for (int d = 0; d < DEVICES; d++) begin
        used[d] <= '0;
      end
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr <= clr + ADDR_W'(1);
          if (clr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            cmd      <= head;
            stat     <= ffsa_pkg::STAT_OK;
            alloc_ok <= 1'b0;
            dev_it   <= '0;
            pos      <= '0;
            case (head.item.kind)
              ffsa_pkg::KIND_ALLOC: begin
                if (cfg.seg == 16'd0 || head.item.size_mb == 24'd0) begin
                  stat  <= ffsa_pkg::STAT_MISALIGN;
                  state <= ST_RESP;
                end else begin
                  div_go <= 1'b1;
                  div_a  <= head.item.size_mb;
                  state  <= ST_DIV_SIZE;
                end
              end
              ffsa_pkg::KIND_REL: begin
                if (cfg.seg == 16'd0) begin
                  stat  <= ffsa_pkg::STAT_MISALIGN;
                  state <= ST_RESP;
                end else begin
                  div_go <= 1'b1;
                  div_a  <= head.item.size_mb;
                  state  <= ST_DIV_SIZE;
                end
              end
              ffsa_pkg::KIND_ALL: begin
                state <= ST_ALL_RD;
              end
              default: begin
                state <= ST_RESP;
              end
            endcase
          end
        end
        ST_DIV_SIZE: begin
          if (div_done) begin
            quot_s <= div_q;
            rem_s  <= div_r;
            if (cmd.item.kind == ffsa_pkg::KIND_REL) begin
              div_go <= 1'b1;
              div_a  <= cmd.item.offset_mb_in;
              state  <= ST_DIV_OFFS;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_DIV_OFFS: begin
          if (div_done) begin
            idx <= div_q;
            if (div_r != 16'd0) begin
              rem_s <= div_r;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          cnt   <= quot_s;
          state <= ST_RESP;
          if (rem_s != 16'd0) begin
            stat <= ffsa_pkg::STAT_MISALIGN;
          end else if (!cmd.item.vm_exists) begin
            stat <= ffsa_pkg::STAT_NO_VM;
          end else if (!cmd.dev_hit) begin
            stat <= ffsa_pkg::STAT_NO_DEV;
          end else if (cmd.item.kind == ffsa_pkg::KIND_ALLOC) begin
            if (quot_s > 24'(cur_total)) begin
              stat <= ffsa_pkg::STAT_NO_SPACE;
            end else begin
              need  <= quot_s[TW-1:0];
              run   <= '0;
              rv    <= 1'b0;
              state <= ST_SCAN;
            end
          end else if (quot_s != 24'd0) begin
            state <= ST_REL_RD;
          end
        end
        ST_SCAN: begin
          // Read data arrives in the cycle after its address is issued.
          if (rv && !taken_q && run_inc == need) begin
            start_seg <= cpos - need + TW'(1);
            pos       <= cpos - need + TW'(1);
            end_pos   <= cpos;
            state     <= ST_CLAIM;
          end else if (!rv && !issue) begin
            stat  <= ffsa_pkg::STAT_NO_SPACE;
            state <= ST_RESP;
          end else begin
            if (rv) begin
              run <= taken_q ? '0 : run_inc;
            end
            if (issue) begin
              pos <= pos + TW'(1);
            end
            rv <= issue;
          end
        end
        ST_CLAIM: begin
          used[cmd.dev_idx[DEV_W-1:0]] <= used[cmd.dev_idx[DEV_W-1:0]] + TW'(1);
          pos <= pos + TW'(1);
          if (pos == end_pos) begin
            state <= ST_MULT;
          end
        end
        ST_MULT: begin
          prod     <= 29'(start_seg) * 29'(cfg.seg);
          alloc_ok <= 1'b1;
          state    <= ST_RESP;
        end
        ST_REL_RD: begin
          if (idx >= 24'(cur_total)) begin
            stat  <= ffsa_pkg::STAT_MISMATCH;
            state <= ST_RESP;
          end else begin
            state <= ST_REL_CHK;
          end
        end
        ST_REL_CHK: begin
          if (own_hit) begin
            used[cmd.dev_idx[DEV_W-1:0]] <= used[cmd.dev_idx[DEV_W-1:0]] - TW'(1);
            idx <= idx + 24'd1;
            cnt <= cnt - 24'd1;
            state <= (cnt == 24'd1) ? ST_RESP : ST_REL_RD;
          end else begin
            stat  <= ffsa_pkg::STAT_MISMATCH;
            state <= ST_RESP;
          end
        end
        ST_ALL_RD: begin
          if (3'(dev_it) >= cfg.dev_n) begin
            state <= ST_RESP;
          end else if (!issue) begin
            dev_it <= dev_it + DEVC_W'(1);
            pos    <= '0;
          end else begin
            state <= ST_ALL_CHK;
          end
        end
        ST_ALL_CHK: begin
          if (own_hit) begin
            used[dev_it[DEV_W-1:0]] <= used[dev_it[DEV_W-1:0]] - TW'(1);
          end
          pos   <= pos + TW'(1);
          state <= ST_ALL_RD;
        end
        ST_RESP: begin
          done                 <= 1'b1;
          result.status        <= stat;
          result.device_index  <= alloc_ok ? cmd.dev_idx : 2'd0;
          result.offset_mb_out <= alloc_ok ? prod[23:0] : 24'd0;
          result.granted_mb    <= alloc_ok ? cmd.item.size_mb : 24'd0;
          result.alignment_mb  <= alloc_ok ? cfg.seg : 16'd0;
          state                <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `AST_HOLD(a_done_idle, clk, rst, !done || state == ST_IDLE, "result strobe outside idle")
  `AST_HOLD(a_scan_bound, clk, rst, state != ST_SCAN || pos <= cur_total, "scan past device end")
  `AST_NEXT(a_claim_seq, clk, rst, state == ST_CLAIM, state == ST_CLAIM || state == ST_MULT, "claim left early")
  `AST_HOLD(a_no_pop_clear, clk, rst, !(state == ST_CLEAR && pop), "item taken during clear")

endmodule

[src/first_fit_segment_allocator_top.sv]
// Top level of the first-fit segment allocator.
`timescale 1ns / 1ps
// Usage:
//   Items enter on start/item; one is accepted at a clock edge where start is
//   high and busy is low. Each item yields exactly one result, shown on result
//   for a single cycle with done high; the receiver cannot stall it. The user
//   must write configuration on cfg_we/cfg_index/cfg_data while idle, unchecked.
// Reset:
//   After rst the segment-taken map is swept to free, all DEVICES*SEGMENTS
//   entries (16384 by default), with busy held high.
// Work per item, by walks over the map memory:
//   allocate: divide and checks, then a scan of one segment per cycle for a
//     free run up to the device total, then a claim of each granted segment;
//   release range: two divides, then a read and a check per freed segment;
//   release all: a read and a check per segment of every device in use.
//   Errors found after the divides end the item there; a zero segment
//   size or a zero allocate size, and unused kinds, go straight to the result.
// A two-entry queue holds items taken by the front end while the back end
// works, so up to two items can be accepted ahead of the one in progress.
module first_fit_segment_allocator_top #(
  parameter int DEVICES    = ffsa_pkg::DEVICES_DEF,
  parameter int SEGMENTS   = ffsa_pkg::SEGMENTS_DEF,
  parameter int VM_ID_BITS = ffsa_pkg::VM_ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ffsa_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [28:0]       cfg_data,
  output logic              done,
  output ffsa_pkg::result_t result
);

  ffsa_pkg::cfg_t cfg;
  ffsa_pkg::cmd_t push_cmd;
  ffsa_pkg::cmd_t head;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  logic back_ready;

  // Hold config, match the device, push into the queue.
  ffsa_front #(.DEVICES(DEVICES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start      (start),
    .item       (item),
    .back_ready (back_ready),
    .q_full     (q_full),
    .busy       (busy),
    .push       (push),
    .cmd        (push_cmd),
    .cfg        (cfg)
  );

  ffsa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Divide, walk the map, emit the result.
  ffsa_back #(
    .DEVICES    (DEVICES),
    .SEGMENTS   (SEGMENTS),
    .VM_ID_BITS (VM_ID_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .ready   (back_ready),
    .done    (done),
    .result  (result)
  );

endmodule
